[sv/iidl_pkg.sv]
// Shared types and constants for the indexed insert/delete list.
// No dependencies; used by the cell and the top level.
package iidl_pkg;

  // Widest cell index supported (capacity up to 1024 entries)
  localparam int IDX_W = 10;

  typedef logic [IDX_W-1:0] idx_t;

  // Command codes carried on the input channel
  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_READ      = 3'd3,
    CMD_OVERWRITE = 3'd4,
    CMD_PEEK      = 3'd5,
    CMD_LENGTH    = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does on an accepted command
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  // Broadcast control from the command decoder to the cell row
  typedef struct packed {
    logic     en;      // a command was accepted this cycle
    cell_op_t op;
    idx_t     pos;     // target index of insert, delete or write
    logic     rd_en;   // read or peek that passed its checks
    idx_t     rd_idx;  // entry to return
  } cell_ctl_t;

endpackage

[sv/iidl_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on nothing; payload widths follow the list's field widths.
interface iidl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [6:0]  position;
  logic [31:0] entry_data;

  modport source (output valid, command, position, entry_data, input ready);
  modport sink   (input valid, command, position, entry_data, output ready);
endinterface

interface iidl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [6:0]  length;

  modport source (output valid, status, read_data, length, input ready);
  modport sink   (input valid, status, read_data, length, output ready);
endinterface

[sv/indexed_insert_delete_list_core.sv]
// Top level of the indexed insert/delete list: command decode, cell row, result register.
// Depends on iidl_pkg, iidl_in_if/iidl_out_if and iidl_cell.
//
//   channel  dir  transfer when          payload
//   in_ch    in   in_ch.valid & ready    command, position, entry_data
//   out_ch   out  out_ch.valid & ready   status, read_data, length
//
// One command per cycle sustained while the output is not stalled. A command's
// result passes through the pending register into the output register; the
// cell row updates all entries in parallel at the accept edge. Synchronous
// active-low reset empties the list; entry contents are not cleared. A stalled
// output holds one pending result, and the input stalls only while both are full.
module indexed_insert_delete_list_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  iidl_in_if.sink          in_ch,
  iidl_out_if.source       out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  // Entry count and decode
  logic [CW-1:0]            cnt_r, cnt_nxt;
  iidl_pkg::cell_ctl_t      ctl;
  iidl_pkg::status_t        st;
  iidl_pkg::cmd_t           cmd;
  logic [CMPW-1:0]          posx, cntx;
  logic                     full, accept;
  logic [DATA_WIDTH-1:0]    wr_val;

  // Pending result and output register
  logic                     pend_r, pend_nxt;
  iidl_pkg::status_t        pst_r;
  logic [6:0]               plen_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [31:0]              out_data_r;
  logic [6:0]               out_len_r;
  logic                     move;
  logic [DATA_WIDTH-1:0]    rd_any;

  // Cell row wiring
  logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]    cell_rd   [CAPACITY];

  assign move         = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !pend_r || move;
  assign accept       = in_ch.valid && in_ch.ready;

  assign cmd    = iidl_pkg::cmd_t'(in_ch.command);
  assign posx   = CMPW'(in_ch.position);
  assign cntx   = CMPW'(cnt_r);
  assign full   = (cnt_r == CW'(CAPACITY));
  assign wr_val = DATA_WIDTH'(in_ch.entry_data);

  // Command decode: checks, cell control, next count
  always_comb begin
    st         = iidl_pkg::ST_OK;
    cnt_nxt    = cnt_r;
    ctl.en     = accept;
    ctl.op     = iidl_pkg::CELL_HOLD;
    ctl.pos    = iidl_pkg::idx_t'(in_ch.position);
    ctl.rd_en  = 1'b0;
    ctl.rd_idx = iidl_pkg::idx_t'(in_ch.position);
    unique case (cmd)
      iidl_pkg::CMD_APPEND: begin
        if (full) begin
          st = iidl_pkg::ST_FULL;
        end else begin
          ctl.op  = iidl_pkg::CELL_WRITE;
          ctl.pos = iidl_pkg::idx_t'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      iidl_pkg::CMD_INSERT: begin
        if (posx > cntx) begin
          st = iidl_pkg::ST_RANGE;
        end else if (full) begin
          st = iidl_pkg::ST_FULL;
        end else begin
          ctl.op  = iidl_pkg::CELL_INSERT;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      iidl_pkg::CMD_DELETE: begin
        if (posx >= cntx) begin
          st = iidl_pkg::ST_RANGE;
        end else begin
          ctl.op  = iidl_pkg::CELL_DELETE;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      iidl_pkg::CMD_READ: begin
        if (posx >= cntx) st = iidl_pkg::ST_RANGE;
        else ctl.rd_en = 1'b1;
      end
      iidl_pkg::CMD_OVERWRITE: begin
        if (posx >= cntx) st = iidl_pkg::ST_RANGE;
        else ctl.op = iidl_pkg::CELL_WRITE;
      end
      iidl_pkg::CMD_PEEK: begin
        if (cnt_r == '0) begin
          st = iidl_pkg::ST_RANGE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = iidl_pkg::idx_t'(cnt_r - 1'b1);
        end
      end
      iidl_pkg::CMD_LENGTH: begin
        st = iidl_pkg::ST_OK;
      end
      iidl_pkg::CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: st = iidl_pkg::ST_OK;
    endcase
    if (!accept) begin
      ctl.op    = iidl_pkg::CELL_HOLD;
      ctl.rd_en = 1'b0;
    end
  end

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    if (i == 0) begin : g_lo
      assign left_d = cell_data[i];
    end else begin : g_lo
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_d = cell_data[i];
    end else begin : g_hi
      assign right_d = cell_data[i+1];
    end
    iidl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_data    (wr_val),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // Merge of the registered cell read values (at most one is nonzero)
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | cell_rd[k];
    end
  end

  // Control state
  always_comb begin
    pend_nxt = pend_r;
    if (move) pend_nxt = 1'b0;
    if (accept) pend_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (move) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) cnt_r <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pending and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pst_r  <= st;
      plen_r <= 7'(cnt_nxt);
    end
    if (move) begin
      out_status_r <= pst_r;
      out_data_r   <= 32'(rd_any);
      out_len_r    <= plen_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.length    = out_len_r;

`ifndef SYNTHESIS
  // Count never exceeds the number of cells
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A pending result is kept while the output register stays full
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_ch.ready |=> pend_r)
    else $error("pending result lost under stall");

  // Every accepted command leaves a pending result
  a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r)
    else $error("accepted command left no result");

  // Failed commands return no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != iidl_pkg::ST_OK) |-> out_data_r == '0)
    else $error("error result carries data");
`endif

endmodule

[sv/iidl_cell.sv]
// One storage cell of the list: holds one entry and trades it with its neighbors.
// Depends on iidl_pkg for the broadcast control struct.
module iidl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                     clk,
  input  iidl_pkg::cell_ctl_t      ctl,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  input  logic [DATA_WIDTH-1:0]    left_data,   // entry of the cell below
  input  logic [DATA_WIDTH-1:0]    right_data,  // entry of the cell above
  output logic [DATA_WIDTH-1:0]    data_o,
  output logic [DATA_WIDTH-1:0]    rd_o         // entry if selected, else zero
);

  localparam iidl_pkg::idx_t MY_IDX = iidl_pkg::idx_t'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;

  // Next entry value
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      iidl_pkg::CELL_INSERT: begin
        if (MY_IDX > ctl.pos) data_nxt = left_data;
        else if (MY_IDX == ctl.pos) data_nxt = wr_data;
      end
      iidl_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctl.pos) data_nxt = right_data;
      end
      iidl_pkg::CELL_WRITE: begin
        if (MY_IDX == ctl.pos) data_nxt = wr_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Read capture, taken from the entry before this command's update
  assign rd_nxt = (ctl.rd_en && (MY_IDX == ctl.rd_idx)) ? data_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      data_r <= data_nxt;
      rd_r   <= rd_nxt;
    end
  end

  assign data_o = data_r;
  assign rd_o   = rd_r;

endmodule
